// ===== hdl/duration_text_to_seconds_defines.svh =====
// assertion macros for the duration text parser
`ifndef DURATION_TEXT_TO_SECONDS_DEFINES_SVH
`define DURATION_TEXT_TO_SECONDS_DEFINES_SVH

`ifndef SYNTHESIS
`define DTTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dtts check failed");
`define DTTS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("dtts reset check failed");
`else
`define DTTS_ASSERT(lbl, prop)
`define DTTS_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== hdl/dtts_pkg.sv =====
package dtts_pkg;

  localparam int unsigned MaxTotal = 32'd2147483647;

  localparam int unsigned SecWeek = 7 * 24 * 3600;
  localparam int unsigned SecDay  = 24 * 3600;
  localparam int unsigned SecHour = 3600;
  localparam int unsigned SecMin  = 60;
  localparam int unsigned SecSec  = 1;

  localparam logic [30:0] LimWeek = 31'(MaxTotal / SecWeek);
  localparam logic [30:0] LimDay  = 31'(MaxTotal / SecDay);
  localparam logic [30:0] LimHour = 31'(MaxTotal / SecHour);
  localparam logic [30:0] LimMin  = 31'(MaxTotal / SecMin);
  localparam logic [30:0] LimSec  = 31'(MaxTotal / SecSec);

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChWLo   = 8'h77;
  localparam logic [7:0] ChWUp   = 8'h57;
  localparam logic [7:0] ChDLo   = 8'h64;
  localparam logic [7:0] ChDUp   = 8'h44;
  localparam logic [7:0] ChHLo   = 8'h68;
  localparam logic [7:0] ChHUp   = 8'h48;
  localparam logic [7:0] ChMLo   = 8'h6d;
  localparam logic [7:0] ChMUp   = 8'h4d;
  localparam logic [7:0] ChSLo   = 8'h73;
  localparam logic [7:0] ChSUp   = 8'h53;

  localparam logic [31:0] DigitSat = 32'h8000_0000;

  typedef enum logic [3:0] {
    PhTop    = 4'b0001,
    PhSpaces = 4'b0010,
    PhDigits = 4'b0100,
    PhJunk   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic        known;
    logic [19:0] mult;
    logic [30:0] limit;
  } unit_t;

  function automatic unit_t unit_lookup(input logic [7:0] c);
    unit_t u;
    u = '{known: 1'b1, mult: 20'd0, limit: 31'd0};
    unique case (c) inside
      ChWLo, ChWUp: begin
        u.mult  = 20'(SecWeek);
        u.limit = LimWeek;
      end
      ChDLo, ChDUp: begin
        u.mult  = 20'(SecDay);
        u.limit = LimDay;
      end
      ChHLo, ChHUp: begin
        u.mult  = 20'(SecHour);
        u.limit = LimHour;
      end
      ChMLo, ChMUp: begin
        u.mult  = 20'(SecMin);
        u.limit = LimMin;
      end
      ChSLo, ChSUp: begin
        u.mult  = 20'(SecSec);
        u.limit = LimSec;
      end
      default: begin
        u.known = 1'b0;
      end
    endcase
    return u;
  endfunction

endpackage

// ===== hdl/duration_text_to_seconds.sv =====
// Duration text parser: bytes of a text such as "1w2d3h4m5s" arrive one per word on the
// slave side, ending with a zero byte. Each zero byte yields exactly one result word on the
// master side: bit 0 is ok, bits 31:1 the total in seconds (zero when ok is low). Groups are
// optional spaces, decimal digits and a unit letter w, d, h, m or s in either case; junk after
// a unit is skipped. Missing digits, unknown units, overflow past 2147483647, a text ending
// after spaces or digits, and a zero total all give ok low. The block takes one byte every
// cycle; only a zero byte waits, and only while the previous result still sits unaccepted in
// the output register. A result word passes from its zero byte through the input register
// and then the result register before it is offered on the master side. A group's product
// is added to the total in the cycle after its unit letter.
`include "duration_text_to_seconds_defines.svh"

module duration_text_to_seconds
  import dtts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // ok, seconds
);

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_char_q;
  logic        adv;
  logic        is_nul, is_space, is_digit;

  phase_e      phase_q, phase_d;
  logic [31:0] digit_q, digit_d;
  logic [30:0] total_q, total_d;
  logic [30:0] part_q, part_d;
  logic        failed_q, failed_d;

  logic        out_valid_q, out_valid_d;
  logic        out_ok_q, out_ok_d;
  logic [30:0] out_sec_q, out_sec_d;

  logic [31:0] sum;
  logic        failed_eff;
  logic [35:0] acc;
  logic [31:0] acc_sat;
  logic [50:0] prod;
  unit_t       unit;
  logic        ok_now;

  assign adv = in_valid_q && (!is_nul || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_valid_d = s_axis_tvalid ? 1'b1 : (adv ? 1'b0 : in_valid_q);

  assign is_nul   = (in_char_q == ChNul);
  assign is_space = (in_char_q == ChSpace);
  assign is_digit = (in_char_q >= ChZero) && (in_char_q <= ChNine);

  // pending group product folds into the total in the cycle after its unit letter
  assign sum        = {1'b0, total_q} + {1'b0, part_q};
  assign failed_eff = failed_q || sum[31];

  assign acc = ({4'b0, digit_q} << 3) + ({4'b0, digit_q} << 1) + {32'b0, in_char_q[3:0]};
  assign acc_sat = (acc > {4'b0, DigitSat}) ? DigitSat : acc[31:0];

  assign unit = unit_lookup(in_char_q);
  assign prod = digit_q[30:0] * unit.mult;

  assign ok_now = !failed_eff && (phase_q == PhTop || phase_q == PhJunk) &&
                  (sum[30:0] != 31'd0);

  always_comb begin
    phase_d     = phase_q;
    digit_d     = digit_q;
    total_d     = sum[30:0];
    part_d      = 31'd0;
    failed_d    = failed_eff;
    out_ok_d    = out_ok_q;
    out_sec_d   = out_sec_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;

    if (adv) begin
      if (is_nul) begin
        out_valid_d = 1'b1;
        out_ok_d    = ok_now;
        out_sec_d   = ok_now ? sum[30:0] : 31'd0;
        phase_d     = PhTop;
        digit_d     = 32'd0;
        total_d     = 31'd0;
        failed_d    = 1'b0;
      end else if (!failed_eff) begin
        unique case (phase_q)
          PhTop, PhSpaces: begin
            if (is_space) begin
              phase_d = PhSpaces;
            end else if (is_digit) begin
              digit_d = {28'd0, in_char_q[3:0]};
              phase_d = PhDigits;
            end else begin
              failed_d = 1'b1;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              digit_d = acc_sat;
            end else if (!unit.known || digit_q > {1'b0, unit.limit}) begin
              failed_d = 1'b1;
            end else begin
              part_d  = prod[30:0];
              digit_d = 32'd0;
              phase_d = PhJunk;
            end
          end
          PhJunk: begin
            if (is_space) begin
              phase_d = PhSpaces;
            end else if (is_digit) begin
              digit_d = {28'd0, in_char_q[3:0]};
              phase_d = PhDigits;
            end
          end
          default: begin
            phase_d = PhTop;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PhTop;
      digit_q     <= 32'd0;
      total_q     <= 31'd0;
      part_q      <= 31'd0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      digit_q     <= digit_d;
      total_q     <= total_d;
      part_q      <= part_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_char_q <= s_axis_tdata;
    end
    out_ok_q  <= out_ok_d;
    out_sec_q <= out_sec_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_sec_q, out_ok_q};

  // end of text returns the parser to its idle state
  `DTTS_ASSERT(a_nul_clears, (adv && is_nul) |=>
               (phase_q == PhTop && total_q == 31'd0 && !failed_q && part_q == 31'd0))
  // a pending group product is cleared once it has been added to the total
  `DTTS_ASSERT(a_part_once, (part_q != 31'd0) |=> (part_q == 31'd0))
  // an error sticks until the end of the text
  `DTTS_ASSERT(a_failed_sticky, (failed_q && !(adv && is_nul)) |=> failed_q)
  // a passing result never carries a zero total, a failing one never a nonzero total
  `DTTS_ASSERT(a_ok_sec, out_valid_q |-> (out_ok_q == (out_sec_q != 31'd0)))
  `DTTS_ASSERT_RST(a_rst_quiet, !rst_ni |-> (!out_valid_q && !in_valid_q))

endmodule
